FILE: design/esd_pkg.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Shared types, character codes and lookup functions for the decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_OPEN = 2'd2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;

   localparam logic [7:0] CODE_BEL = 8'h07;
   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_HT  = 8'h09;
   localparam logic [7:0] CODE_VT  = 8'h0B;

   localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       end_of_string;
   } result_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } escape_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.hit   = 1'b0;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.hit   = 1'b1;
         h.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.hit   = 1'b1;
         h.value = c[3:0] - 4'd1 + HEX_LETTER_BASE;
      end
      return h;
   endfunction

   function automatic escape_type simple_escape(input logic [7:0] c);
      escape_type e;
      e.hit  = 1'b1;
      e.code = c;
      unique case (c)
         CHAR_A: e.code = CODE_BEL;
         CHAR_B: e.code = CODE_BS;
         CHAR_F: e.code = CODE_FF;
         CHAR_N: e.code = CODE_LF;
         CHAR_R: e.code = CODE_CR;
         CHAR_T: e.code = CODE_HT;
         CHAR_V: e.code = CODE_VT;
         CHAR_QUOTE, CHAR_DQUOTE, CHAR_QUESTION, CHAR_BACKSLASH: e.code = c;
         default: e.hit = 1'b0;
      endcase
      return e;
   endfunction

endpackage

FILE: design/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes a C-style escaped string, one character per request.
// ----------------------------------------------------------------------------
// Each request carries one character and a flag on the final character of
// the string. The block takes a request every clock cycle: a request is held
// in an input register, decoded in one pass against the escape state, and
// its result, if any, is loaded into an output register once that register
// has room. Escape openers and a first hex digit give no result; an
// invalid escape gives one error result and the rest of the string is
// dropped up to its final character. Status 0 is a good byte, 1 an invalid
// escape or hex digit, 2 a string that ended inside an escape. The block
// only stops taking requests while a result waits for the downstream side.
module escape_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_string
);
   import esd_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       advance;
   logic       room;
   result_type result;

   // The held request moves on when its result, if any, has somewhere to go.
   assign advance   = in_valid_ff && (!result.valid || room);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   esd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .ch      (in_ch_ff),
      .last    (in_last_ff),
      .advance (advance),
      .result  (result)
   );

   esd_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && result.valid),
      .result            (result),
      .room              (room),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule

FILE: design/esd_decode.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder core
// Holds the escape mode and pending hex digit, and works out the result
// for the registered input character in a single pass.
// ----------------------------------------------------------------------------
module esd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          ch,
   input  logic                last,
   input  logic                advance,
   output esd_pkg::result_type result
);
   import esd_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [3:0] nibble_ff, nibble_in;
   hex_type    hex;
   escape_type esc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         nibble_ff <= 4'd0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
      end
   end

   always_comb begin
      hex                  = hex_digit(ch);
      esc                  = simple_escape(ch);
      mode_in              = mode_ff;
      nibble_in            = nibble_ff;
      result.valid         = 1'b0;
      result.out_byte      = 8'd0;
      result.status        = STATUS_OK;
      result.end_of_string = last;

      unique case (mode_ff)
         MODE_DROP: begin
            mode_in = MODE_NORMAL;
            if (!last) begin
               mode_in = MODE_DROP;
            end
         end
         MODE_ESC: begin
            if (esc.hit) begin
               result.valid    = 1'b1;
               result.out_byte = esc.code;
               mode_in         = MODE_NORMAL;
            end else if (ch == CHAR_X) begin
               if (last) begin
                  result.valid  = 1'b1;
                  result.status = STATUS_OPEN;
                  mode_in       = MODE_NORMAL;
               end else begin
                  mode_in = MODE_HEX1;
               end
            end else begin
               result.valid  = 1'b1;
               result.status = STATUS_BAD;
               mode_in       = last ? MODE_NORMAL : MODE_DROP;
            end
         end
         MODE_HEX1: begin
            if (!hex.hit) begin
               result.valid  = 1'b1;
               result.status = STATUS_BAD;
               mode_in       = last ? MODE_NORMAL : MODE_DROP;
            end else if (last) begin
               result.valid  = 1'b1;
               result.status = STATUS_OPEN;
               mode_in       = MODE_NORMAL;
            end else begin
               nibble_in = hex.value;
               mode_in   = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            result.valid = 1'b1;
            if (!hex.hit) begin
               result.status = STATUS_BAD;
               mode_in       = last ? MODE_NORMAL : MODE_DROP;
            end else begin
               result.out_byte = {nibble_ff, hex.value};
               mode_in         = MODE_NORMAL;
            end
         end
         default: begin
            // The unused mode codes decode as plain text.
            if (ch == CHAR_BACKSLASH) begin
               if (last) begin
                  result.valid  = 1'b1;
                  result.status = STATUS_OPEN;
                  mode_in       = MODE_NORMAL;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else begin
               result.valid    = 1'b1;
               result.out_byte = ch;
               mode_in         = MODE_NORMAL;
            end
         end
      endcase

      if (last) begin
         nibble_in = 4'd0;
      end
   end

endmodule

FILE: design/esd_out_stage.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module esd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  esd_pkg::result_type result,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_status,
   output logic                rsp_end_of_string
);
   import esd_pkg::*;

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic [1:0] status_ff;
   logic       eos_ff;

   // The register may be reloaded in the same cycle as its content leaves.
   assign room = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && room) begin
         byte_ff   <= result.out_byte;
         status_ff <= result.status;
         eos_ff    <= result.end_of_string;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_status        = status_ff;
   assign rsp_end_of_string = eos_ff;

endmodule

FILE: design/esd_checker.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder checker
// Port-level checks on the result channel and request ready, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status
);
   import esd_pkg::*;

   // A result that is waiting must not be withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // Error results carry a zero byte.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_out_byte == 8'd0)
      else $error("error result with non-zero byte");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_BAD ||
                     rsp_status == STATUS_OPEN))
      else $error("undefined status code");

   // A result cannot appear before any request has been accepted.
   a_no_early_rsp: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");

   // With the result register free or draining, requests are always taken.
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused while the result register had room");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status)
);

FILE: test/escape_sequence_decoder_tb.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Drives escaped strings one character per request, predicts every decoded
// byte, error and end-of-string flag, and checks the result stream in order.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb;
   import esd_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         hold;
   } char_req_type;

   typedef struct {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       end_of_string;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_end_of_string;

   char_req_type char_q[$];
   decoded_type  decoded_q[$];
   int         accepted_count = 0;
   int         fails = 0;
   int         send_gap = 0;
   int         send_burst = 0;
   int         sink_stall = 0;
   int         sink_burst = 0;

   // Own copy of the decoder state.
   mode_type   dec_mode = MODE_NORMAL;
   logic [3:0] dec_nibble = 4'd0;

   escape_sequence_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_end_of_string (rsp_end_of_string)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int hex_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input int v, input bit lower);
      if (v < 10) return 8'("0" + v);
      return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   // Advances the decoder state by one character; returns 1 when a result is due.
   function automatic bit decode_char(input logic [7:0] ch, input logic last,
                                      output decoded_type r);
      int         h;
      bit         hit;
      logic [1:0] st;
      logic [7:0] val;
      hit = 1'b1;
      st  = STATUS_OK;
      val = ch;
      h   = hex_of(ch);
      r   = '{8'h00, STATUS_OK, 1'b0};
      case (dec_mode)
         MODE_DROP: begin
            hit = 1'b0;
            if (last) begin
               dec_mode   = MODE_NORMAL;
               dec_nibble = 4'd0;
            end
         end
         MODE_ESC: begin
            dec_mode = MODE_NORMAL;
            case (ch)
               CHAR_A: val = CODE_BEL;
               CHAR_B: val = CODE_BS;
               CHAR_F: val = CODE_FF;
               CHAR_N: val = CODE_LF;
               CHAR_R: val = CODE_CR;
               CHAR_T: val = CODE_HT;
               CHAR_V: val = CODE_VT;
               CHAR_QUOTE, CHAR_DQUOTE, CHAR_QUESTION, CHAR_BACKSLASH: val = ch;
               CHAR_X: begin
                  if (last) st = STATUS_OPEN;
                  else begin
                     dec_mode = MODE_HEX1;
                     hit      = 1'b0;
                  end
               end
               default: st = STATUS_BAD;
            endcase
         end
         MODE_HEX1: begin
            if (h < 0) st = STATUS_BAD;
            else if (last) st = STATUS_OPEN;
            else begin
               dec_nibble = h[3:0];
               dec_mode   = MODE_HEX2;
               hit        = 1'b0;
            end
         end
         MODE_HEX2: begin
            if (h < 0) st = STATUS_BAD;
            else begin
               dec_mode   = MODE_NORMAL;
               val        = {dec_nibble, h[3:0]};
               dec_nibble = 4'd0;
            end
         end
         default: begin
            if (ch == CHAR_BACKSLASH) begin
               if (last) st = STATUS_OPEN;
               else begin
                  dec_mode = MODE_ESC;
                  hit      = 1'b0;
               end
            end else begin
               dec_mode = MODE_NORMAL;
            end
         end
      endcase
      if (hit) begin
         r.out_byte      = (st == STATUS_OK) ? val : 8'h00;
         r.status        = st;
         r.end_of_string = last;
         if (last) begin
            dec_mode   = MODE_NORMAL;
            dec_nibble = 4'd0;
         end else if (st == STATUS_BAD) begin
            dec_mode = MODE_DROP;
         end
      end
      return hit;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a burst with none.
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic push_char(input logic [7:0] ch, input logic last, input bit hold);
      char_q.push_back('{ch, last, hold});
   endtask

   always @(posedge clock) begin : drive_proc
      char_req_type it;
      decoded_type  res;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (decode_char(req_ch, req_last, res)) decoded_q.push_back(res);
            accepted_count++;
         end
         if (req_valid && !req_ready) begin
            // The request is still waiting; hold it unchanged.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (char_q.size() > 0 && (!char_q[0].hold || decoded_q.size() == 0)) begin
            it = char_q.pop_front();
            req_ch    <= it.ch;
            req_last  <= it.last;
            req_valid <= 1'b1;
            send_gap = pick_gap(send_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_proc
      decoded_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result: out_byte %h, status %0d, end_of_string %0b",
                      rsp_out_byte, rsp_status, rsp_end_of_string);
               fails++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
                  fails++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fails++;
               end
               if (rsp_end_of_string !== want.end_of_string) begin
                  $error("end_of_string: expected %0b, actual %0b",
                         want.end_of_string, rsp_end_of_string);
                  fails++;
               end
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            sink_stall = pick_gap(sink_burst);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] str[$];
      logic [7:0] c;
      int         ntok;
      int         r;
      int         k;
      int         n_directed;
      int         total;
      bit         first;

      // Plain bytes at both extremes, zero included.
      push_char(8'h00, 1'b0, 1'b0);
      push_char(8'hFF, 1'b1, 1'b0);
      // A control escape followed by a mixed-case hex escape.
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_A, 1'b0, 1'b0);
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_X, 1'b0, 1'b0);
      push_char("A", 1'b0, 1'b0);
      push_char("f", 1'b1, 1'b0);
      // Invalid escape, then the rest is dropped up to a final backslash.
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char("q", 1'b0, 1'b0);
      push_char("Z", 1'b0, 1'b0);
      push_char(CHAR_BACKSLASH, 1'b1, 1'b0);
      // Strings that end inside an escape.
      push_char(CHAR_BACKSLASH, 1'b1, 1'b0);
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_X, 1'b1, 1'b0);
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_X, 1'b0, 1'b0);
      push_char("4", 1'b1, 1'b0);
      // A bad hex digit on the final character reports an error, not an open escape.
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_X, 1'b0, 1'b0);
      push_char("g", 1'b1, 1'b0);
      push_char(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_char(CHAR_DQUOTE, 1'b1, 1'b0);
      n_directed = char_q.size();

      first = 1'b1;
      while (char_q.size() < n_directed + 1650) begin
         str.delete();
         ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         for (k = 0; k < ntok; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               str.push_back(8'($urandom_range(0, 255)));
            end else if (r < 70) begin
               str.push_back(CHAR_BACKSLASH);
               case ($urandom_range(0, 10))
                  0: str.push_back(CHAR_A);
                  1: str.push_back(CHAR_B);
                  2: str.push_back(CHAR_F);
                  3: str.push_back(CHAR_N);
                  4: str.push_back(CHAR_R);
                  5: str.push_back(CHAR_T);
                  6: str.push_back(CHAR_V);
                  7: str.push_back(CHAR_QUOTE);
                  8: str.push_back(CHAR_DQUOTE);
                  9: str.push_back(CHAR_QUESTION);
                  default: str.push_back(CHAR_BACKSLASH);
               endcase
            end else if (r < 88) begin
               str.push_back(CHAR_BACKSLASH);
               str.push_back(CHAR_X);
               str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
               str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end else if (r < 94) begin
               do c = 8'($urandom_range(0, 255));
               while (c inside {CHAR_A, CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T, CHAR_V,
                                CHAR_QUOTE, CHAR_DQUOTE, CHAR_QUESTION, CHAR_BACKSLASH,
                                CHAR_X});
               str.push_back(CHAR_BACKSLASH);
               str.push_back(c);
            end else begin
               str.push_back(CHAR_BACKSLASH);
               str.push_back(CHAR_X);
               if ($urandom_range(0, 1))
                  str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
               do c = 8'($urandom_range(0, 255));
               while (hex_of(c) >= 0);
               str.push_back(c);
            end
         end
         // Now and then the string is cut off inside an escape.
         if ($urandom_range(0, 99) < 12) begin
            str.push_back(CHAR_BACKSLASH);
            if ($urandom_range(0, 1)) begin
               str.push_back(CHAR_X);
               if ($urandom_range(0, 1))
                  str.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
         end
         for (k = 0; k < str.size(); k++)
            push_char(str[k], k == str.size() - 1,
                      k == 0 && (first || $urandom_range(0, 99) == 0));
         first = 1'b0;
      end
      total = char_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == total);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0)
         $display("escape_sequence_decoder_tb OK");
      else
         $display("escape_sequence_decoder_tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("escape_sequence_decoder_tb NOT OK");
      $finish;
   end

endmodule
